// File: sv/smbus_read_word_master_top_macros.svh
// Assertion macros used by the SMBus read-word master sequencer.
`ifndef SMBUS_READ_WORD_MASTER_TOP_MACROS_SVH
`define SMBUS_READ_WORD_MASTER_TOP_MACROS_SVH

// A property that holds on every clock edge outside reset.
`define SMBRW_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// A condition that must be followed by another one in the next cycle.
`define SMBRW_ASSERT_NEXT(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) else $error(msg);

`endif

// File: sv/smbrw_pkg.sv
// Types, constants and timing table of the SMBus read-word master.
package smbrw_pkg;

	// Sequence steps of one read-word transaction.
	typedef enum logic [3:0] {
		ST_IDLE   = 4'd0,
		ST_START1 = 4'd1,
		ST_ADDRW  = 4'd2,
		ST_CMD    = 4'd3,
		ST_START2 = 4'd4,
		ST_ADDRR  = 4'd5,
		ST_RLOW   = 4'd6,
		ST_RHIGH  = 4'd7,
		ST_RPEC   = 4'd8,
		ST_STOP   = 4'd9
	} step_t;

	// Configuration register indexes.
	localparam logic [7:0] CFG_SLAVE_ADDRESS  = 8'd0;
	localparam logic [7:0] CFG_COMMAND_CODE   = 8'd1;
	localparam logic [7:0] CFG_TICKS_PER_UNIT = 8'd2;
	localparam logic [7:0] CFG_TEMP_OFFSET    = 8'd3;

	// Configuration reset values.
	localparam logic [6:0]  SLAVE_ADDRESS_RST  = 7'd0;
	localparam logic [7:0]  COMMAND_CODE_RST   = 8'd7;
	localparam logic [7:0]  TICKS_PER_UNIT_RST = 8'd1;
	localparam logic [15:0] TEMP_OFFSET_RST    = 16'd27230;

	// One input item.
	typedef struct packed {
		logic kind;
		logic sda_in;
	} req_t;

	// One result item.
	typedef struct packed {
		logic               scl_level;
		logic               sda_release;
		logic               busy_res;
		logic               done_res;
		logic               nack_error;
		logic [15:0]        raw_word;
		logic [7:0]         pec_byte;
		logic signed [17:0] temp_centi;
	} rsp_t;

	// Bus settings used by the sequencer.
	typedef struct packed {
		logic [6:0] slave_address;
		logic [7:0] command_code;
		logic [7:0] ticks_per_unit;
	} seq_cfg_t;

	// Sequencer status after one item.
	typedef struct packed {
		logic        scl_level;
		logic        sda_release;
		logic        busy;
		logic        done;
		logic        nack;
		logic [15:0] raw_word;
		logic [7:0]  pec_byte;
	} seq_res_t;

	// Length of a bus phase in delay units.
	function automatic logic [3:0] phase_units(step_t step, logic [1:0] sub, logic read_slot);
		logic [3:0] units;
		units = 4'd4;
		case (step) inside
			ST_START1, ST_START2: begin
				case (sub)
					2'd0: units = 4'd1;
					2'd1: units = 4'd5;
					2'd2: units = 4'd10;
					default: units = 4'd4;
				endcase
			end
			ST_STOP: begin
				case (sub)
					2'd0: units = 4'd5;
					2'd1: units = 4'd5;
					2'd2: units = 4'd10;
					default: units = 4'd1;
				endcase
			end
			default: begin
				if (read_slot) begin
					units = sub[0] ? 4'd4 : 4'd10;
				end else begin
					case (sub)
						2'd0: units = 4'd5;
						2'd1: units = 4'd10;
						default: units = 4'd4;
					endcase
				end
			end
		endcase
		return units;
	endfunction

endpackage

// File: sv/smbrw_seq.sv
// Bus sequencer: step state machine, bit timing and received bytes.
`include "smbus_read_word_master_top_macros.svh"

module smbrw_seq
	import smbrw_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     adv,
	input  req_t     item,
	input  seq_cfg_t cfg,
	output seq_res_t res
);

	step_t       step_q, step_d;
	logic [1:0]  sub_q, sub_d;
	logic [11:0] phase_q, phase_d;
	logic [3:0]  bit_q, bit_d;
	logic [7:0]  shift_q, shift_d;
	logic [7:0]  low_q, low_d;
	logic [7:0]  high_q, high_d;
	logic [7:0]  pec_q, pec_d;
	logic        nack_q, nack_d;
	logic        scl_q, scl_d;
	logic        sda_q, sda_d;
	logic        done;

	logic        send_step, recv_step, edge_step, stop_step;
	logic        read_slot;
	logic        start_go, tick;
	logic [7:0]  tpu_eff;
	logic [3:0]  units;
	logic [11:0] limit;
	logic [11:0] phase_inc;
	logic        phase_done;
	logic [1:0]  sub_max;
	logic        sub_last;
	logic        slot_end;

	// Step classification and phase timing.
	assign send_step = (step_q == ST_ADDRW) || (step_q == ST_CMD) || (step_q == ST_ADDRR);
	assign recv_step = (step_q == ST_RLOW) || (step_q == ST_RHIGH) || (step_q == ST_RPEC);
	assign edge_step = (step_q == ST_START1) || (step_q == ST_START2);
	assign stop_step = (step_q == ST_STOP);
	assign read_slot = send_step ? bit_q[3] : !bit_q[3];

	assign start_go = adv && item.kind && (step_q == ST_IDLE);
	assign tick     = adv && !item.kind && (step_q != ST_IDLE);

	assign tpu_eff    = (cfg.ticks_per_unit == 8'd0) ? 8'd1 : cfg.ticks_per_unit;
	assign units      = phase_units(step_q, sub_q, read_slot);
	assign limit      = {4'b0, tpu_eff} * {8'b0, units};
	assign phase_inc  = phase_q + 12'd1;
	assign phase_done = phase_inc >= limit;

	// Last sub-phase: four for start and stop, two for a read bit, three for a sent bit.
	always_comb begin
		if (edge_step || stop_step) begin
			sub_max = 2'd3;
		end else if (read_slot) begin
			sub_max = 2'd1;
		end else begin
			sub_max = 2'd2;
		end
	end
	assign sub_last = sub_q == sub_max;
	assign slot_end = tick && phase_done && sub_last;

	// Next step of the transaction.
	always_comb begin
		step_d = step_q;
		if (start_go) begin
			step_d = ST_START1;
		end else if (slot_end) begin
			unique case (step_q) inside
				ST_START1: step_d = ST_ADDRW;
				ST_START2: step_d = ST_ADDRR;
				ST_STOP:   step_d = ST_IDLE;
				ST_ADDRW, ST_CMD, ST_ADDRR: begin
					if (bit_q[3]) begin
						if (shift_q[0]) begin
							step_d = ST_STOP;
						end else if (step_q == ST_ADDRW) begin
							step_d = ST_CMD;
						end else if (step_q == ST_CMD) begin
							step_d = ST_START2;
						end else begin
							step_d = ST_RLOW;
						end
					end
				end
				ST_RLOW:  if (bit_q[3]) step_d = ST_RHIGH;
				ST_RHIGH: if (bit_q[3]) step_d = ST_RPEC;
				ST_RPEC:  if (bit_q[3]) step_d = ST_STOP;
				default:  step_d = step_q;
			endcase
		end
	end

	// Line levels, counters, shift register and received bytes.
	always_comb begin
		sub_d   = sub_q;
		phase_d = phase_q;
		bit_d   = bit_q;
		shift_d = shift_q;
		low_d   = low_q;
		high_d  = high_q;
		pec_d   = pec_q;
		nack_d  = nack_q;
		scl_d   = scl_q;
		sda_d   = sda_q;
		done    = slot_end && stop_step;

		if (start_go) begin
			nack_d = 1'b0;
		end

		if (tick) begin
			// Levels of a phase are driven on its first tick.
			if (phase_q == 12'd0) begin
				if (edge_step) begin
					case (sub_q)
						2'd0: sda_d = 1'b1;
						2'd1: scl_d = 1'b1;
						2'd2: sda_d = 1'b0;
						default: scl_d = 1'b0;
					endcase
				end else if (stop_step) begin
					case (sub_q)
						2'd0: scl_d = 1'b0;
						2'd1: sda_d = 1'b0;
						2'd2: scl_d = 1'b1;
						default: sda_d = 1'b1;
					endcase
				end else if (read_slot) begin
					if (sub_q == 2'd0) begin
						scl_d = 1'b1;
						sda_d = 1'b1;
					end else begin
						scl_d = 1'b0;
					end
				end else begin
					case (sub_q)
						2'd0: sda_d = send_step ? shift_q[7] : 1'b0;
						2'd1: scl_d = 1'b1;
						default: scl_d = 1'b0;
					endcase
				end
			end

			phase_d = phase_inc;
			if (phase_done) begin
				phase_d = 12'd0;
				// Sample SDA at the end of the clock-high phase of a read bit.
				if (sub_q == 2'd0 && recv_step && !bit_q[3]) begin
					shift_d = {shift_q[6:0], item.sda_in};
				end else if (sub_q == 2'd0 && send_step && bit_q[3]) begin
					shift_d = {7'b0, item.sda_in};
				end

				if (sub_last) begin
					sub_d = 2'd0;
					if ((send_step || recv_step) && !bit_q[3]) begin
						if (send_step) begin
							shift_d = {shift_q[6:0], 1'b0};
						end
						bit_d = bit_q + 4'd1;
					end
					if (send_step && bit_q[3] && shift_q[0]) begin
						nack_d = 1'b1;
					end
					if (recv_step && bit_q[3]) begin
						case (step_q)
							ST_RLOW:  low_d  = shift_q;
							ST_RHIGH: high_d = shift_q;
							default:  pec_d  = shift_q;
						endcase
					end
				end else begin
					sub_d = sub_q + 2'd1;
				end
			end
		end

		// Entering a new step restarts its counters and loads the byte to send.
		if (step_d != step_q) begin
			sub_d   = 2'd0;
			phase_d = 12'd0;
			bit_d   = 4'd0;
			case (step_d)
				ST_ADDRW: shift_d = {cfg.slave_address, 1'b0};
				ST_CMD:   shift_d = cfg.command_code;
				ST_ADDRR: shift_d = {cfg.slave_address, 1'b1};
				default:  shift_d = 8'd0;
			endcase
		end
	end

	// Sequencer state registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q  <= ST_IDLE;
			sub_q   <= 2'd0;
			phase_q <= 12'd0;
			bit_q   <= 4'd0;
			shift_q <= 8'd0;
			low_q   <= 8'd0;
			high_q  <= 8'd0;
			pec_q   <= 8'd0;
			nack_q  <= 1'b0;
			scl_q   <= 1'b1;
			sda_q   <= 1'b1;
		end else if (adv) begin
			step_q  <= step_d;
			sub_q   <= sub_d;
			phase_q <= phase_d;
			bit_q   <= bit_d;
			shift_q <= shift_d;
			low_q   <= low_d;
			high_q  <= high_d;
			pec_q   <= pec_d;
			nack_q  <= nack_d;
			scl_q   <= scl_d;
			sda_q   <= sda_d;
		end
	end

	// Status after this item.
	assign res.scl_level   = scl_d;
	assign res.sda_release = sda_d;
	assign res.busy        = step_d != ST_IDLE;
	assign res.done        = done;
	assign res.nack        = nack_d;
	assign res.raw_word    = {high_d, low_d};
	assign res.pec_byte    = pec_d;

	`SMBRW_ASSERT(a_bit_range, bit_q <= 4'd8, "bit index beyond the acknowledge slot")
	`SMBRW_ASSERT(a_phase_range, (step_q != ST_IDLE) |-> (phase_q < limit), "phase counter overran its phase")
	`SMBRW_ASSERT(a_idle_released, (step_q == ST_IDLE) |-> (scl_q && sda_q), "bus held while idle")
	`SMBRW_ASSERT_NEXT(a_start, start_go, step_q == ST_START1, "start request did not arm the sequence")
	`SMBRW_ASSERT_NEXT(a_done_idle, adv && done, step_q == ST_IDLE, "transaction ended without going idle")

endmodule

// File: sv/smbus_read_word_master_top.sv
// Top level of the SMBus read-word master: ports, configuration and pipeline registers.
//
// Usage: each item on the req channel is either a tick (kind 0) carrying the
// sampled SDA level, or a request to begin a read-word transaction (kind 1).
// A begin on a busy master is ignored. Each tick advances the bus sequence by
// one tick; each item gives exactly one result on the rsp channel with the SCL
// level and SDA release to drive, busy, a done pulse, the nack flag, the raw
// word, the PEC byte and the temperature raw*2 minus the offset in hundredths.
// Registers are written on the cfg channel (index, data), which is always ready;
// write them only while no item is in flight.
// A result passes through one input register and one result register, with
// the sequencer logic between them. Throughput is one item per cycle while
// rsp_stall is low. When rsp_stall is high the result register holds its
// item; req_stall follows rsp_stall in the same cycle once both registers
// hold an item, so an empty input register still takes one more item.
// Reset clears both registers to empty, the bus lines to released high, the
// received bytes and the nack flag to zero, and loads the register defaults.

module smbus_read_word_master_top
	import smbrw_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	output logic        req_stall,
	input  req_t        req,
	output logic        rsp_valid,
	input  logic        rsp_stall,
	output rsp_t        rsp,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [7:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	logic [6:0]  slave_address_q;
	logic [7:0]  command_code_q;
	logic [7:0]  ticks_per_unit_q;
	logic [15:0] temp_offset_q;

	logic        req_valid_s1;
	req_t        req_s1;
	logic        rsp_valid_q;
	rsp_t        rsp_q;

	logic        out_free;
	logic        adv;
	seq_cfg_t    seq_cfg;
	seq_res_t    seq_res;
	rsp_t        rsp_d;
	logic [17:0] temp_d;

	// Configuration registers.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slave_address_q  <= SLAVE_ADDRESS_RST;
			command_code_q   <= COMMAND_CODE_RST;
			ticks_per_unit_q <= TICKS_PER_UNIT_RST;
			temp_offset_q    <= TEMP_OFFSET_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_SLAVE_ADDRESS:  slave_address_q  <= cfg_data[6:0];
				CFG_COMMAND_CODE:   command_code_q   <= cfg_data[7:0];
				CFG_TICKS_PER_UNIT: ticks_per_unit_q <= cfg_data[7:0];
				CFG_TEMP_OFFSET:    temp_offset_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	// Handshake: the input stage moves on whenever the result register can load.
	assign out_free  = !rsp_valid_q || !rsp_stall;
	assign adv       = req_valid_s1 && out_free;
	assign req_stall = req_valid_s1 && !out_free;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid_s1 <= 1'b0;
		end else if (!req_stall) begin
			req_valid_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!req_stall && req_valid) begin
			req_s1 <= req;
		end
	end

	// Bus sequencer.
	assign seq_cfg.slave_address  = slave_address_q;
	assign seq_cfg.command_code   = command_code_q;
	assign seq_cfg.ticks_per_unit = ticks_per_unit_q;

	smbrw_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (adv),
		.item   (req_s1),
		.cfg    (seq_cfg),
		.res    (seq_res)
	);

	// Result assembly; the temperature wraps to 18 bits.
	assign temp_d = {1'b0, seq_res.raw_word, 1'b0} - {2'b00, temp_offset_q};

	assign rsp_d.scl_level   = seq_res.scl_level;
	assign rsp_d.sda_release = seq_res.sda_release;
	assign rsp_d.busy_res    = seq_res.busy;
	assign rsp_d.done_res    = seq_res.done;
	assign rsp_d.nack_error  = seq_res.nack;
	assign rsp_d.raw_word    = seq_res.raw_word;
	assign rsp_d.pec_byte    = seq_res.pec_byte;
	assign rsp_d.temp_centi  = $signed(temp_d);

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (adv) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rsp_q <= rsp_d;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

// File: bench/tb.sv
// Self-checking testbench for the SMBus read-word master top level.
`timescale 1ns / 100ps

module tb;
	import smbrw_pkg::*;

	// Item kinds on the request channel.
	localparam logic KIND_TICK  = 1'b0;
	localparam logic KIND_BEGIN = 1'b1;

	// Cycles allowed after the last result before the block counts as idle.
	localparam int DRAIN_CYCLES   = 4;
	localparam int WATCHDOG_LIMIT = 2000;

	// Behavior of the emulated slave for one read-word transaction.
	typedef struct packed {
		logic [2:0] nack_at;	// bit 0 write address, bit 1 command, bit 2 read address
		logic [7:0] low_b;
		logic [7:0] high_b;
		logic [7:0] pec_b;
	} slave_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        req_valid = 1'b0;
	logic        req_stall;
	req_t        req = '0;
	logic        rsp_valid;
	logic        rsp_stall = 1'b0;
	rsp_t        rsp;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [7:0]  cfg_index = '0;
	logic [15:0] cfg_data = '0;

	// Predicted bus status items waiting for the block's results.
	rsp_t bus_status_q[$];

	bit jitter_on = 1'b1;
	int unsigned quiet_cycles = 0;
	int unsigned n_errors = 0;
	int unsigned n_items = 0;
	int unsigned n_checked = 0;
	int unsigned n_ended = 0;
	int unsigned n_nacked = 0;

	// Shadow of the configuration and the sequencer state.
	logic [6:0]  m_addr;
	logic [7:0]  m_cmd;
	logic [7:0]  m_tpu;
	logic [15:0] m_off;
	step_t       m_step;
	logic [11:0] m_phase;
	int unsigned m_sub;
	logic [3:0]  m_bit;
	logic [7:0]  m_shift;
	logic [7:0]  m_lo;
	logic [7:0]  m_hi;
	logic [7:0]  m_pec;
	logic        m_nack;
	logic        m_scl;
	logic        m_sda;

	smbus_read_word_master_top u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// Clock with a 12 ns period.
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Mostly short gaps, now and then a long one; none while jitter is off.
	function automatic int unsigned gap_len();
		int unsigned r;
		if (!jitter_on) begin
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 90) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 10);
		return $urandom_range(11, 30);
	endfunction

	function automatic req_t mk_req(logic k, logic s);
		req_t it;
		it.kind = k;
		it.sda_in = s;
		return it;
	endfunction

	function automatic bit is_send(step_t s);
		return s inside {ST_ADDRW, ST_CMD, ST_ADDRR};
	endfunction

	// A read slot: data bits of a received byte or the acknowledge of a sent one.
	function automatic bit in_read_slot();
		if (is_send(m_step)) begin
			return m_bit >= 4'd8;
		end
		return m_bit < 4'd8;
	endfunction

	function automatic void seq_enter(step_t s);
		m_step = s;
		m_sub = 0;
		m_phase = '0;
		m_bit = '0;
		case (s)
			ST_ADDRW: m_shift = {m_addr, 1'b0};
			ST_CMD:   m_shift = m_cmd;
			ST_ADDRR: m_shift = {m_addr, 1'b1};
			default:  m_shift = '0;
		endcase
	endfunction

	function automatic void seq_reset();
		m_addr = SLAVE_ADDRESS_RST;
		m_cmd = COMMAND_CODE_RST;
		m_tpu = TICKS_PER_UNIT_RST;
		m_off = TEMP_OFFSET_RST;
		seq_enter(ST_IDLE);
		m_lo = '0;
		m_hi = '0;
		m_pec = '0;
		m_nack = 1'b0;
		m_scl = 1'b1;
		m_sda = 1'b1;
	endfunction

	// Line levels set on the first tick of a phase.
	function automatic void seq_levels();
		logic b;
		case (m_step)
			ST_START1, ST_START2: begin
				case (m_sub)
					0: m_sda = 1'b1;
					1: m_scl = 1'b1;
					2: m_sda = 1'b0;
					default: m_scl = 1'b0;
				endcase
			end
			ST_STOP: begin
				case (m_sub)
					0: m_scl = 1'b0;
					1: m_sda = 1'b0;
					2: m_scl = 1'b1;
					default: m_sda = 1'b1;
				endcase
			end
			default: begin
				if (in_read_slot()) begin
					if (m_sub == 0) begin
						m_scl = 1'b1;
						m_sda = 1'b1;
					end else begin
						m_scl = 1'b0;
					end
				end else begin
					// The master acknowledges received bytes by pulling SDA low.
					b = is_send(m_step) ? m_shift[7] : 1'b0;
					case (m_sub)
						0: m_sda = b;
						1: m_scl = 1'b1;
						default: m_scl = 1'b0;
					endcase
				end
			end
		endcase
	endfunction

	// Length of the current phase in delay units, and the phase count of the slot.
	function automatic int unsigned seq_units(output int unsigned nsub);
		case (m_step)
			ST_START1, ST_START2: begin
				nsub = 4;
				case (m_sub)
					0: return 1;
					1: return 5;
					2: return 10;
					default: return 4;
				endcase
			end
			ST_STOP: begin
				nsub = 4;
				case (m_sub)
					0: return 5;
					1: return 5;
					2: return 10;
					default: return 1;
				endcase
			end
			default: begin
				if (in_read_slot()) begin
					nsub = 2;
					return (m_sub == 0) ? 10 : 4;
				end
				nsub = 3;
				case (m_sub)
					0: return 5;
					1: return 10;
					default: return 4;
				endcase
			end
		endcase
	endfunction

	// One tick of an active transaction; returns 1 on the tick that ends it.
	function automatic bit seq_tick(logic sda_s);
		int unsigned units;
		int unsigned nsub;
		int unsigned tpu;
		step_t s;
		s = m_step;
		if (m_phase == 0) begin
			seq_levels();
		end
		units = seq_units(nsub);
		tpu = (m_tpu == 0) ? 1 : m_tpu;
		m_phase = m_phase + 12'd1;
		if (m_phase < units * tpu) begin
			return 1'b0;
		end
		m_phase = '0;

		// SDA is sampled at the end of the high part of a read slot.
		if (m_sub == 0 && s inside {ST_RLOW, ST_RHIGH, ST_RPEC} && m_bit < 4'd8) begin
			m_shift = {m_shift[6:0], sda_s};
		end else if (m_sub == 0 && is_send(s) && m_bit >= 4'd8) begin
			m_shift = {7'd0, sda_s};
		end

		m_sub++;
		if (m_sub < nsub) begin
			return 1'b0;
		end
		m_sub = 0;

		if (s == ST_START1 || s == ST_START2) begin
			seq_enter(step_t'(s + 4'd1));
			return 1'b0;
		end
		if (s == ST_STOP) begin
			seq_enter(ST_IDLE);
			return 1'b1;
		end
		if (m_bit < 4'd8) begin
			if (is_send(s)) begin
				m_shift = {m_shift[6:0], 1'b0};
			end
			m_bit++;
			return 1'b0;
		end
		if (is_send(s)) begin
			if (m_shift[0]) begin
				m_nack = 1'b1;
				seq_enter(ST_STOP);
			end else begin
				seq_enter(step_t'(s + 4'd1));
			end
			return 1'b0;
		end
		case (s)
			ST_RLOW:  m_lo = m_shift;
			ST_RHIGH: m_hi = m_shift;
			default:  m_pec = m_shift;
		endcase
		seq_enter(step_t'(s + 4'd1));
		return 1'b0;
	endfunction

	// Expected bus status after one accepted item.
	function automatic rsp_t predict_bus_status(req_t it);
		rsp_t r;
		logic [15:0] raw;
		bit ended;
		ended = 1'b0;
		if (it.kind == KIND_BEGIN) begin
			// A begin on a busy master is ignored.
			if (m_step == ST_IDLE) begin
				m_nack = 1'b0;
				seq_enter(ST_START1);
			end
		end else if (m_step != ST_IDLE) begin
			ended = seq_tick(it.sda_in);
		end
		raw = {m_hi, m_lo};
		r.scl_level = m_scl;
		r.sda_release = m_sda;
		r.busy_res = (m_step != ST_IDLE);
		r.done_res = ended;
		r.nack_error = m_nack;
		r.raw_word = raw;
		r.pec_byte = m_pec;
		r.temp_centi = {1'b0, raw, 1'b0} - {2'b00, m_off};
		return r;
	endfunction

	// SDA level the emulated slave presents on the next tick.
	function automatic logic slave_sda(slave_t sl);
		if (m_sub == 0) begin
			case (m_step)
				ST_ADDRW: if (m_bit >= 4'd8) return sl.nack_at[0];
				ST_CMD:   if (m_bit >= 4'd8) return sl.nack_at[1];
				ST_ADDRR: if (m_bit >= 4'd8) return sl.nack_at[2];
				ST_RLOW:  if (m_bit < 4'd8) return sl.low_b[3'd7 - m_bit[2:0]];
				ST_RHIGH: if (m_bit < 4'd8) return sl.high_b[3'd7 - m_bit[2:0]];
				ST_RPEC:  if (m_bit < 4'd8) return sl.pec_b[3'd7 - m_bit[2:0]];
				default: ;
			endcase
		end
		return $urandom_range(0, 1);
	endfunction

	// Sends one item, waits until it is accepted and records its expected status.
	task automatic send_item(input req_t it);
		int unsigned gap;
		rsp_t want;
		gap = gap_len();
		if (gap != 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		req <= it;
		do @(posedge clk); while (req_stall);
		want = predict_bus_status(it);
		bus_status_q.push_back(want);
		n_items++;
		if (want.done_res) begin
			n_ended++;
			if (want.nack_error) n_nacked++;
		end
	endtask

	// Stops sending and waits until every expected result has come back.
	task automatic drain();
		req_valid <= 1'b0;
		while (bus_status_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Writes all four registers while the block is idle.
	task automatic set_config(input logic [6:0] addr, input logic [7:0] cmd,
			input logic [7:0] tpu, input logic [15:0] off);
		logic [7:0]  idx [4];
		logic [15:0] val [4];
		drain();
		idx = '{CFG_SLAVE_ADDRESS, CFG_COMMAND_CODE, CFG_TICKS_PER_UNIT, CFG_TEMP_OFFSET};
		val = '{{9'd0, addr}, {8'd0, cmd}, {8'd0, tpu}, off};
		cfg_valid <= 1'b1;
		for (int i = 0; i < 4; i++) begin
			cfg_index <= idx[i];
			cfg_data <= val[i];
			do @(posedge clk); while (!cfg_ready);
		end
		cfg_valid <= 1'b0;
		m_addr = addr;
		m_cmd = cmd;
		m_tpu = tpu;
		m_off = off;
	endtask

	// Runs one read-word transaction against the emulated slave until it ends.
	task automatic run_transaction(input slave_t sl, input bit noisy);
		send_item(mk_req(KIND_BEGIN, $urandom_range(0, 1)));
		if (noisy) begin
			send_item(mk_req(KIND_BEGIN, $urandom_range(0, 1)));
		end
		while (m_step != ST_IDLE) begin
			if (noisy && $urandom_range(0, 63) == 0) begin
				send_item(mk_req(KIND_BEGIN, $urandom_range(0, 1)));
			end else begin
				send_item(mk_req(KIND_TICK, slave_sda(sl)));
			end
		end
	endtask

	// Receiver stalls: runs of acceptance broken by stalls of random length.
	initial begin : rsp_backpressure
		int unsigned hold;
		forever begin
			rsp_stall <= 1'b0;
			repeat (1 + $urandom_range(0, 6)) @(posedge clk);
			hold = gap_len();
			if (hold != 0) begin
				rsp_stall <= 1'b1;
				repeat (hold) @(posedge clk);
			end
		end
	end

	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			n_errors++;
			if (n_errors <= 10) begin
				$display("%0t: %s mismatch, expected %0h, got %0h", $realtime, name, want, got);
			end
		end
	endtask

	// Compares each accepted result with the oldest expected status.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)
					|| (cfg_valid && cfg_ready)) begin
				quiet_cycles <= 0;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
			if (rsp_valid && !rsp_stall) begin
				if (bus_status_q.size() == 0) begin
					n_errors++;
					if (n_errors <= 10) begin
						$display("%0t: result with no expected status waiting", $realtime);
					end
				end else begin
					rsp_t want;
					want = bus_status_q.pop_front();
					n_checked++;
					check_field("scl_level", want.scl_level, rsp.scl_level);
					check_field("sda_release", want.sda_release, rsp.sda_release);
					check_field("busy_res", want.busy_res, rsp.busy_res);
					check_field("done_res", want.done_res, rsp.done_res);
					check_field("nack_error", want.nack_error, rsp.nack_error);
					check_field("raw_word", want.raw_word, rsp.raw_word);
					check_field("pec_byte", want.pec_byte, rsp.pec_byte);
					check_field("temp_centi", want.temp_centi, rsp.temp_centi);
				end
			end
		end
	end

	// Ends the run when nothing moves for too long.
	initial begin : watchdog
		while (quiet_cycles < WATCHDOG_LIMIT) @(posedge clk);
		$display("Timeout: no transaction for %0d cycles", WATCHDOG_LIMIT);
		$display("end of test: mismatches");
		$finish;
	end

	// Ticks on an idle master, right after reset: lines released, held values zero.
	task automatic test_idle_ticks();
		send_item(mk_req(KIND_TICK, 1'b0));
		send_item(mk_req(KIND_TICK, 1'b1));
		send_item(mk_req(KIND_TICK, 1'b0));
		drain();
	endtask

	// Write address not acknowledged, zero tick count, begins while busy.
	task automatic test_address_nack();
		slave_t sl;
		set_config(7'h7F, 8'hFF, 8'd0, 16'hFFFF);
		sl = '{nack_at: 3'b001, low_b: 8'h00, high_b: 8'h00, pec_b: 8'h00};
		run_transaction(sl, 1'b1);
		send_item(mk_req(KIND_TICK, 1'b1));
		send_item(mk_req(KIND_TICK, 1'b0));
		drain();
	endtask

	// Command byte acknowledged, read address not: repeated start, then a stop,
	// with ticks sent back to back and no receiver stalls.
	task automatic test_read_address_nack();
		slave_t sl;
		set_config(7'h13, 8'h5A, 8'd1, 16'd27230);
		jitter_on = 1'b0;
		sl = '{nack_at: 3'b100, low_b: 8'h11, high_b: 8'h22, pec_b: 8'h33};
		run_transaction(sl, 1'b0);
		drain();
		jitter_on = 1'b1;
	endtask

	initial begin
		seq_reset();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		test_idle_ticks();
		test_address_nack();
		test_read_address_nack();
		drain();
		$display("Covered %0d items and %0d bus transactions, %0d of them ended on a missing",
			n_items, n_ended, n_nacked);
		$display("acknowledge; %0d results checked, %0d mismatches.", n_checked, n_errors);
		if (n_errors == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule

// File: smbus_read_word_master_top.f
+incdir+sv
sv/smbrw_pkg.sv
sv/smbrw_seq.sv
sv/smbus_read_word_master_top.sv
bench/tb.sv
